// ===== hdl/rtpts_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rtpts_pkg
// Shared types and constants for the RTP / MPEG-TS depacketizer.
// ---------------------------------------------------------------------------
package rtpts_pkg;

	localparam int DEF_MAX_PACKET_BYTES = 2048;
	localparam int DEF_TS_PACKET_BYTES  = 188;

	localparam int BYTE_W = 8;
	localparam int TYPE_W = 7;
	localparam int SEQ_W  = 16;
	localparam int HDR_W  = 19;
	localparam int PLEN_W = 12;
	localparam int STAT_W = 3;

	localparam logic [BYTE_W-1:0] TS_SYNC          = 8'h47;
	localparam logic [TYPE_W-1:0] DEF_PAYLOAD_TYPE = 7'd33;
	localparam logic [HDR_W-1:0]  RTP_FIXED_BYTES  = 19'd12;
	localparam logic [1:0]        RTP_VERSION      = 2'd2;

	typedef enum logic [STAT_W-1:0] {
		ST_OK_RTP      = 3'd0,
		ST_OK_RAW      = 3'd1,
		ST_TOO_SHORT   = 3'd2,
		ST_BAD_VERSION = 3'd3,
		ST_WRONG_TYPE  = 3'd4,
		ST_BAD_LENGTH  = 3'd5,
		ST_TRUNCATED   = 3'd6
	} rtpts_status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last;
	} rtpts_beat_t;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic              payload_valid;
		logic              packet_end;
		rtpts_status_t     status;
		logic [SEQ_W-1:0]  sequence_number;
		logic [HDR_W-1:0]  header_length;
		logic [PLEN_W-1:0] payload_length;
	} rtpts_result_t;

endpackage
`default_nettype wire

// ===== hdl/rtpts_in_stage.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rtpts_in_stage
// Input register: captures one byte beat and holds it until the parser
// advances it.
// ---------------------------------------------------------------------------
module rtpts_in_stage
	import rtpts_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire rtpts_beat_t beat,
	input  wire logic        advance,
	output logic             valid_s1,
	output rtpts_beat_t      beat_s1
);

	logic accept;

	// stall during reset and while a held beat cannot move on
	assign byte_stall = ~arst_n | (valid_s1 & ~advance);
	assign accept     = byte_valid & ~byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1 <= beat;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/rtpts_parser.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rtpts_parser
// Per-packet header state and the single-pass parse of one byte: header
// field capture, header length, payload gating and end-of-packet status.
// ---------------------------------------------------------------------------
module rtpts_parser
	import rtpts_pkg::*;
#(
	parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES,
	parameter int TS_PACKET_BYTES  = DEF_TS_PACKET_BYTES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire rtpts_beat_t       beat_s1,
	input  wire logic [TYPE_W-1:0] expected_pt,
	output logic                   res_valid,
	output rtpts_result_t          res
);

	localparam int IDX_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int PH_W  = $clog2(TS_PACKET_BYTES + 1);
	localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_PACKET_BYTES);
	localparam logic [PH_W:0]    TS_LEN  = (PH_W+1)'(TS_PACKET_BYTES);

	logic [IDX_W-1:0]  idx_q, idx_n, cnt_q, cnt_n, len;
	logic              raw_q, raw_n;
	logic [1:0]        ver_q, ver_n;
	logic              ext_q, ext_n;
	logic [3:0]        csrc_q, csrc_n;
	logic [TYPE_W-1:0] type_q, type_n;
	logic [SEQ_W-1:0]  seq_q, seq_n;
	logic [HDR_W-1:0]  need_q, need_base, need_n, base, idx_w;
	logic [PH_W-1:0]   phase_q, phase_n;
	logic [PH_W:0]     phase_inc;
	logic [BYTE_W-1:0] b;
	logic              in_range, first, hdr0, rtp, pv;
	rtpts_status_t     status;

	assign b        = beat_s1.data_byte;
	assign in_range = idx_q < MAX_IDX;
	assign first    = idx_q == '0;
	assign idx_w    = HDR_W'(idx_q);

	always_comb begin
		hdr0   = in_range & first & (b != TS_SYNC);
		raw_n  = raw_q | (in_range & first & (b == TS_SYNC));
		ver_n  = hdr0 ? b[7:6] : ver_q;
		ext_n  = hdr0 ? b[4] : ext_q;
		csrc_n = hdr0 ? b[3:0] : csrc_q;
		need_base = hdr0 ? (RTP_FIXED_BYTES + HDR_W'({b[3:0], 2'b00})
			+ (b[4] ? HDR_W'(4) : '0)) : need_q;
		base = RTP_FIXED_BYTES + HDR_W'({csrc_n, 2'b00});
		rtp  = in_range & ~raw_n;

		type_n = (rtp && idx_w == HDR_W'(1)) ? b[TYPE_W-1:0] : type_q;
		seq_n  = seq_q;
		if (rtp && idx_w == HDR_W'(2)) begin
			seq_n[15:8] = b;
		end
		if (rtp && idx_w == HDR_W'(3)) begin
			seq_n[7:0] = b;
		end

		// extension length: high byte in units of 256 words, low byte in words
		need_n = need_base;
		if (rtp && ext_n && idx_w == base + HDR_W'(2)) begin
			need_n = need_base + (HDR_W'(b) << 10);
		end else if (rtp && ext_n && idx_w == base + HDR_W'(3)) begin
			need_n = need_base + (HDR_W'(b) << 2);
		end

		pv = in_range & (raw_n | (~first & (idx_w >= need_n)));

		phase_inc = {1'b0, phase_q} + 1'b1;
		cnt_n   = pv ? cnt_q + 1'b1 : cnt_q;
		phase_n = phase_q;
		if (pv) begin
			phase_n = (phase_inc >= TS_LEN) ? '0 : phase_inc[PH_W-1:0];
		end

		idx_n = in_range ? idx_q + 1'b1 : idx_q;
		len   = in_range ? idx_q + 1'b1 : MAX_IDX;

		priority if (raw_n) begin
			status = ST_OK_RAW;
		end else if (HDR_W'(len) < RTP_FIXED_BYTES) begin
			status = ST_TOO_SHORT;
		end else if (ver_n != RTP_VERSION) begin
			status = ST_BAD_VERSION;
		end else if (type_n != expected_pt) begin
			status = ST_WRONG_TYPE;
		end else if (HDR_W'(len) < need_n) begin
			status = ST_TRUNCATED;
		end else if (cnt_n == '0 || phase_n != '0) begin
			status = ST_BAD_LENGTH;
		end else begin
			status = ST_OK_RTP;
		end

		res_valid           = pv | beat_s1.last;
		res.payload_byte    = pv ? b : '0;
		res.payload_valid   = pv;
		res.packet_end      = beat_s1.last;
		res.status          = beat_s1.last ? status : ST_OK_RTP;
		res.sequence_number = (beat_s1.last && !raw_n) ? seq_n : '0;
		res.header_length   = (beat_s1.last && !raw_n) ? need_n : '0;
		res.payload_length  = beat_s1.last ? PLEN_W'(cnt_n) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			raw_q   <= 1'b0;
			ver_q   <= RTP_VERSION;
			ext_q   <= 1'b0;
			csrc_q  <= '0;
			type_q  <= '0;
			seq_q   <= '0;
			need_q  <= '0;
			cnt_q   <= '0;
			phase_q <= '0;
		end else if (advance) begin
			if (beat_s1.last) begin
				// packet closed: back to the clean state
				idx_q   <= '0;
				raw_q   <= 1'b0;
				ver_q   <= RTP_VERSION;
				ext_q   <= 1'b0;
				csrc_q  <= '0;
				type_q  <= '0;
				seq_q   <= '0;
				need_q  <= '0;
				cnt_q   <= '0;
				phase_q <= '0;
			end else begin
				idx_q   <= idx_n;
				raw_q   <= raw_n;
				ver_q   <= ver_n;
				ext_q   <= ext_n;
				csrc_q  <= csrc_n;
				type_q  <= type_n;
				seq_q   <= seq_n;
				need_q  <= need_n;
				cnt_q   <= cnt_n;
				phase_q <= phase_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/rtpts_out_stage.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rtpts_out_stage
// Result register: holds one result beat until the consumer takes it.
// ---------------------------------------------------------------------------
module rtpts_out_stage
	import rtpts_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire rtpts_result_t res,
	input  wire logic          result_stall,
	output logic               result_valid,
	output logic               free,
	output rtpts_result_t      res_q
);

	assign free = ~result_valid | ~result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (free) begin
			result_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/rtp_mpeg_ts_depacketizer.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rtp_mpeg_ts_depacketizer
// Strips the RTP header from UDP packet bytes, passes MPEG-TS payload on
// and reports per-packet status on the final byte.
// ---------------------------------------------------------------------------
// Each accepted byte is held in the input register, parsed combinationally,
// and its result, if it has one, is registered in the result register.
// Throughput: one byte per cycle while result_stall is low; the input register,
// the single-pass parse and the result register overlap so each stage moves every cycle.
// Bytes that carry neither payload nor the packet end give no result.
// Reset clears all packet state; expected payload type returns to 33.
module rtp_mpeg_ts_depacketizer
	import rtpts_pkg::*;
#(
	parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES,
	parameter int TS_PACKET_BYTES  = DEF_TS_PACKET_BYTES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [TYPE_W-1:0] cfg_wdata,
	input  wire logic              byte_valid,
	output logic                   byte_stall,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              last,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic [BYTE_W-1:0]      payload_byte,
	output logic                   payload_valid,
	output logic                   packet_end,
	output logic [STAT_W-1:0]      status,
	output logic [SEQ_W-1:0]       sequence_number,
	output logic [HDR_W-1:0]       header_length,
	output logic [PLEN_W-1:0]      payload_length
);

	logic [TYPE_W-1:0] expected_pt_q;
	rtpts_beat_t       beat, beat_s1;
	rtpts_result_t     res, res_q;
	logic              valid_s1, advance, res_valid, out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_pt_q <= DEF_PAYLOAD_TYPE;
		end else if (cfg_we) begin
			expected_pt_q <= cfg_wdata;
		end
	end

	assign beat.data_byte = data_byte;
	assign beat.last      = last;
	assign advance        = valid_s1 & out_free;

	rtpts_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.beat       (beat),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.beat_s1    (beat_s1)
	);

	rtpts_parser #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES),
		.TS_PACKET_BYTES  (TS_PACKET_BYTES)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.beat_s1     (beat_s1),
		.expected_pt (expected_pt_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	rtpts_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance & res_valid),
		.res          (res),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.free         (out_free),
		.res_q        (res_q)
	);

	assign payload_byte    = res_q.payload_byte;
	assign payload_valid   = res_q.payload_valid;
	assign packet_end      = res_q.packet_end;
	assign status          = res_q.status;
	assign sequence_number = res_q.sequence_number;
	assign header_length   = res_q.header_length;
	assign payload_length  = res_q.payload_length;

	// every result beat carries payload, a packet end, or both
	a_result_has_content: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (payload_valid || packet_end))
		else $error("result beat with neither payload nor packet end");

	// mid-packet beats carry no packet report
	a_no_report_mid_packet: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !packet_end) |->
		(status == ST_OK_RTP && header_length == '0 && sequence_number == '0
		&& payload_length == '0))
		else $error("packet report outside packet end");

	// raw TS packets report no RTP header
	a_raw_no_header: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && packet_end && status == ST_OK_RAW) |->
		(header_length == '0 && sequence_number == '0))
		else $error("raw TS packet reports an RTP header");

	// a parsed byte never waits while the result register is free
	a_no_stall_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_free) |-> !byte_stall)
		else $error("input stalled while result register free");

endmodule
`default_nettype wire

// ===== test/rtp_mpeg_ts_depacketizer_check.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rtp_mpeg_ts_depacketizer_check
// Watches the byte and result channels of the depacketizer, tracks the RTP
// header parse of every accepted byte, and compares each accepted result
// beat field by field with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module rtp_mpeg_ts_depacketizer_check
	import rtpts_pkg::*;
#(
	parameter int MAX_BYTES = DEF_MAX_PACKET_BYTES,
	parameter int TS_BYTES  = DEF_TS_PACKET_BYTES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [TYPE_W-1:0] cfg_wdata,
	input  wire logic              byte_valid,
	input  wire logic              byte_stall,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              last,
	input  wire logic              result_valid,
	input  wire logic              result_stall,
	input  wire logic [BYTE_W-1:0] payload_byte,
	input  wire logic              payload_valid,
	input  wire logic              packet_end,
	input  wire logic [STAT_W-1:0] status,
	input  wire logic [SEQ_W-1:0]  sequence_number,
	input  wire logic [HDR_W-1:0]  header_length,
	input  wire logic [PLEN_W-1:0] payload_length,
	output int                     errors,
	output int                     waiting,
	output int                     n_reports,
	output int                     n_payload,
	output logic [6:0]             status_mask
);

	// packet parse state
	logic [TYPE_W-1:0] want_type;
	logic [11:0]       pos;
	logic              raw_pkt;
	logic [1:0]        ver_seen;
	logic              ext_seen;
	logic [3:0]        csrc_seen;
	logic [TYPE_W-1:0] type_seen;
	logic [SEQ_W-1:0]  seq_seen;
	logic [HDR_W-1:0]  hdr_need;
	logic [PLEN_W-1:0] pay_count;
	logic [7:0]        ts_pos;

	rtpts_result_t passed_on[$];

	initial begin
		errors      = 0;
		waiting     = 0;
		n_reports   = 0;
		n_payload   = 0;
		status_mask = '0;
	end

	task automatic clear_packet();
		pos       = '0;
		raw_pkt   = 1'b0;
		ver_seen  = RTP_VERSION;
		ext_seen  = 1'b0;
		csrc_seen = '0;
		type_seen = '0;
		seq_seen  = '0;
		hdr_need  = '0;
		pay_count = '0;
		ts_pos    = '0;
	endtask

	task automatic depacketize_byte(input logic [BYTE_W-1:0] b, input logic fin);
		int            idx;
		int            len;
		int            base;
		bit            pv;
		rtpts_status_t st;
		rtpts_result_t r;
		idx = int'(pos);
		pv  = 1'b0;
		if (idx < MAX_BYTES) begin
			if (idx == 0) begin
				if (b == TS_SYNC) begin
					raw_pkt = 1'b1;
				end else begin
					ver_seen  = b[7:6];
					ext_seen  = b[4];
					csrc_seen = b[3:0];
					hdr_need  = RTP_FIXED_BYTES + 19'(csrc_seen) * 19'd4;
					if (ext_seen)
						hdr_need = hdr_need + 19'd4;
				end
			end
			if (raw_pkt) begin
				pv = 1'b1;
			end else begin
				base = 12 + 4 * int'(csrc_seen);
				if (idx == 1)
					type_seen = b[6:0];
				else if (idx == 2)
					seq_seen[15:8] = b;
				else if (idx == 3)
					seq_seen[7:0] = b;
				// extension length word: high byte then low byte, in 32-bit words
				if (ext_seen && idx == base + 2)
					hdr_need = hdr_need + 19'(b) * 19'd1024;
				if (ext_seen && idx == base + 3)
					hdr_need = hdr_need + 19'(b) * 19'd4;
				if (idx != 0 && idx >= int'(hdr_need))
					pv = 1'b1;
			end
			if (pv) begin
				pay_count = pay_count + 1'b1;
				ts_pos = (int'(ts_pos) + 1 >= TS_BYTES) ? 8'd0 : ts_pos + 1'b1;
			end
			pos = 12'(idx + 1);
			len = idx + 1;
		end else begin
			// past the size limit: drop, length saturates
			len = MAX_BYTES;
		end

		if (!pv && !fin)
			return;

		r = '0;
		r.payload_byte  = pv ? b : '0;
		r.payload_valid = pv;
		r.packet_end    = fin;
		r.status        = ST_OK_RTP;
		if (fin) begin
			if (raw_pkt)
				st = ST_OK_RAW;
			else if (len < int'(RTP_FIXED_BYTES))
				st = ST_TOO_SHORT;
			else if (ver_seen != RTP_VERSION)
				st = ST_BAD_VERSION;
			else if (type_seen != want_type)
				st = ST_WRONG_TYPE;
			else if (len < int'(hdr_need))
				st = ST_TRUNCATED;
			else if (pay_count == 0 || ts_pos != 0)
				st = ST_BAD_LENGTH;
			else
				st = ST_OK_RTP;
			r.status          = st;
			r.sequence_number = raw_pkt ? '0 : seq_seen;
			r.header_length   = raw_pkt ? '0 : hdr_need;
			r.payload_length  = pay_count;
			clear_packet();
		end
		passed_on.push_back(r);
	endtask

	task automatic note_mismatch(input string what, input longint unsigned want,
		input longint unsigned got);
		if (errors < 10)
			$display("mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
				what, n_reports + n_payload, want, got);
		errors++;
	endtask

	task automatic check_result();
		rtpts_result_t want;
		if (passed_on.size() == 0) begin
			if (errors < 10)
				$display("result with nothing outstanding: byte 0x%0h pv %0b end %0b st %0d",
					payload_byte, payload_valid, packet_end, status);
			errors++;
			return;
		end
		want = passed_on.pop_front();
		if (payload_byte !== want.payload_byte)
			note_mismatch("payload_byte", want.payload_byte, payload_byte);
		if (payload_valid !== want.payload_valid)
			note_mismatch("payload_valid", want.payload_valid, payload_valid);
		if (packet_end !== want.packet_end)
			note_mismatch("packet_end", want.packet_end, packet_end);
		if (status !== want.status)
			note_mismatch("status", want.status, status);
		if (sequence_number !== want.sequence_number)
			note_mismatch("sequence_number", want.sequence_number, sequence_number);
		if (header_length !== want.header_length)
			note_mismatch("header_length", want.header_length, header_length);
		if (payload_length !== want.payload_length)
			note_mismatch("payload_length", want.payload_length, payload_length);
		if (want.payload_valid)
			n_payload++;
		if (want.packet_end) begin
			n_reports++;
			status_mask[want.status] = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_type = DEF_PAYLOAD_TYPE;
			clear_packet();
			passed_on.delete();
			waiting = 0;
		end else begin
			if (cfg_we)
				want_type = cfg_wdata;
			if (result_valid && !result_stall)
				check_result();
			if (byte_valid && !byte_stall)
				depacketize_byte(data_byte, last);
			waiting = passed_on.size();
		end
	end

endmodule

// ===== test/rtp_mpeg_ts_depacketizer_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rtp_mpeg_ts_depacketizer_tb
// Feeds whole UDP packets into the depacketizer byte by byte: directed
// header corner cases first, then phases of random RTP, raw TS and broken
// packets under several payload-type settings, with random gaps on both
// channels. A separate checker predicts and compares every result beat.
// ---------------------------------------------------------------------------
module rtp_mpeg_ts_depacketizer_tb;
	import rtpts_pkg::*;

	localparam int QUIET_LIMIT = 200;
	localparam int PHASES      = 3;
	localparam int ITEM_BUDGET = 800;
	localparam int BUILD_CAP   = 3000;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cfg_we       = 1'b0;
	logic [TYPE_W-1:0] cfg_wdata    = '0;
	logic              byte_valid   = 1'b0;
	logic              byte_stall;
	logic [BYTE_W-1:0] data_byte    = '0;
	logic              last         = 1'b0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [BYTE_W-1:0] payload_byte;
	logic              payload_valid;
	logic              packet_end;
	logic [STAT_W-1:0] status;
	logic [SEQ_W-1:0]  sequence_number;
	logic [HDR_W-1:0]  header_length;
	logic [PLEN_W-1:0] payload_length;

	int         errors;
	int         waiting;
	int         n_reports;
	int         n_payload;
	logic [6:0] status_mask;

	logic [7:0]        pkt[$];
	logic [TYPE_W-1:0] cur_type  = DEF_PAYLOAD_TYPE;
	bit                tx_idle   = 1'b1;
	bit                rx_idle   = 1'b1;
	bit                rx_taken  = 1'b0;
	int                rx_wait   = 0;
	int                quiet     = 0;
	int                bytes_sent = 0;
	int                n_packets = 0;
	int                n_settings = 1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rtp_mpeg_ts_depacketizer dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.data_byte       (data_byte),
		.last            (last),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.payload_byte    (payload_byte),
		.payload_valid   (payload_valid),
		.packet_end      (packet_end),
		.status          (status),
		.sequence_number (sequence_number),
		.header_length   (header_length),
		.payload_length  (payload_length)
	);

	rtp_mpeg_ts_depacketizer_check depkt_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.data_byte       (data_byte),
		.last            (last),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.payload_byte    (payload_byte),
		.payload_valid   (payload_valid),
		.packet_end      (packet_end),
		.status          (status),
		.sequence_number (sequence_number),
		.header_length   (header_length),
		.payload_length  (payload_length),
		.errors          (errors),
		.waiting         (waiting),
		.n_reports       (n_reports),
		.n_payload       (n_payload),
		.status_mask     (status_mask)
	);

	// receiver: when rx_idle is set, hold stall for a random, possibly zero, wait after each beat
	always @(posedge clk)
		rx_taken <= result_valid && !result_stall;

	always @(negedge clk) begin
		if (rx_taken)
			rx_wait = rx_idle ? $urandom_range(0, 3) : 0;
		if (rx_wait > 0) begin
			result_stall = 1'b1;
			rx_wait--;
		end else begin
			result_stall = 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
				if (quiet == QUIET_LIMIT) begin
					$display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
					$display("rtp_mpeg_ts_depacketizer_tb failed");
					$finish;
				end
			end
		end
	end

	task automatic build_rtp(input logic [1:0] ver, input logic ext, input logic [3:0] cc,
		input logic [6:0] pt, input int ext_words, input int plen);
		logic [15:0] words16;
		int          j;
		words16 = ext_words[15:0];
		pkt.delete();
		pkt.push_back({ver, 1'($urandom), ext, cc});
		pkt.push_back({1'($urandom), pt});
		for (j = 0; j < 10 + 4 * int'(cc); j++)
			pkt.push_back(8'($urandom));
		if (ext) begin
			pkt.push_back(8'($urandom));
			pkt.push_back(8'($urandom));
			pkt.push_back(words16[15:8]);
			pkt.push_back(words16[7:0]);
			for (j = 0; j < 4 * int'(words16) && pkt.size() < BUILD_CAP; j++)
				pkt.push_back(8'($urandom));
		end
		for (j = 0; j < plen; j++)
			pkt.push_back((j % DEF_TS_PACKET_BYTES == 0) ? TS_SYNC : 8'($urandom));
	endtask

	task automatic build_raw(input int n);
		int j;
		pkt.delete();
		pkt.push_back(TS_SYNC);
		for (j = 1; j < n; j++)
			pkt.push_back(8'($urandom));
	endtask

	task automatic build_noise(input int n);
		int j;
		pkt.delete();
		for (j = 0; j < n; j++)
			pkt.push_back(8'($urandom));
	endtask

	task automatic trim(input int n);
		while (pkt.size() > n)
			void'(pkt.pop_back());
	endtask

	task automatic send_packet();
		int i;
		int gap;
		tx_idle = $urandom_range(0, 3) != 0;
		rx_idle = $urandom_range(0, 3) != 0;
		for (i = 0; i < pkt.size(); i++) begin
			gap = tx_idle ? $urandom_range(0, 3) : 0;
			if (gap > 0) begin
				@(negedge clk);
				byte_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			byte_valid = 1'b1;
			data_byte  = pkt[i];
			last       = (i == pkt.size() - 1);
			do @(posedge clk); while (!(byte_valid && !byte_stall));
			bytes_sent++;
		end
		@(negedge clk);
		byte_valid = 1'b0;
		last       = 1'b0;
		n_packets++;
	endtask

	task automatic drain(input int settle);
		while (waiting != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// register writes only once the block has gone quiet
	task automatic set_payload_type(input logic [TYPE_W-1:0] t);
		drain(4);
		cfg_we    = 1'b1;
		cfg_wdata = t;
		@(negedge clk);
		cfg_we    = 1'b0;
		cur_type  = t;
		n_settings++;
	endtask

	task automatic random_packet();
		int          r;
		logic [3:0]  cc;
		logic        ext;
		logic [6:0]  pt;
		r   = $urandom_range(0, 99);
		ext = 1'($urandom);
		cc  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
		pt  = ($urandom_range(0, 9) == 0) ? 7'($urandom) : cur_type;
		if (r < 20) begin
			build_rtp(RTP_VERSION, ext, 4'($urandom_range(0, 2)), pt,
				ext ? $urandom_range(0, 1) : 0, DEF_TS_PACKET_BYTES);
		end else if (r < 45) begin
			build_rtp(RTP_VERSION, ext, cc, pt, ext ? $urandom_range(0, 3) : 0,
				$urandom_range(0, 40));
			if ($urandom_range(0, 1) == 0)
				trim($urandom_range(1, pkt.size()));
		end else if (r < 65) begin
			// broken header: any version, any extension length
			build_rtp(2'($urandom), ext, 4'($urandom), 7'($urandom), $urandom_range(0, 65535),
				$urandom_range(0, 40));
			trim($urandom_range(1, 40));
		end else if (r < 85) begin
			build_raw($urandom_range(1, 40));
		end else begin
			build_noise($urandom_range(1, 30));
		end
		send_packet();
	endtask

	initial begin
		int ph;
		int phase_end;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: default type after reset, header shapes, raw TS, error codes
		build_rtp(RTP_VERSION, 1'b1, 4'd1, DEF_PAYLOAD_TYPE, 1, 188);
		send_packet();
		build_raw(30);
		send_packet();
		build_raw(1);
		send_packet();
		build_rtp(RTP_VERSION, 1'b0, 4'd0, DEF_PAYLOAD_TYPE, 0, 188);
		trim(1);
		send_packet();
		build_rtp(RTP_VERSION, 1'b0, 4'd0, DEF_PAYLOAD_TYPE, 0, 188);
		trim(11);
		send_packet();
		build_rtp(RTP_VERSION, 1'b0, 4'd0, DEF_PAYLOAD_TYPE, 0, 0);
		send_packet();
		build_rtp(2'd0, 1'b0, 4'd0, DEF_PAYLOAD_TYPE, 0, 188);
		trim(20);
		send_packet();
		build_rtp(2'd3, 1'b0, 4'd0, DEF_PAYLOAD_TYPE, 0, 188);
		trim(20);
		send_packet();
		build_rtp(RTP_VERSION, 1'b0, 4'd0, DEF_PAYLOAD_TYPE + 1'b1, 0, 188);
		trim(20);
		send_packet();
		build_rtp(RTP_VERSION, 1'b0, 4'd15, DEF_PAYLOAD_TYPE, 0, 188);
		trim(40);
		send_packet();
		build_rtp(RTP_VERSION, 1'b1, 4'd0, DEF_PAYLOAD_TYPE, 65535, 0);
		trim(30);
		send_packet();
		build_rtp(RTP_VERSION, 1'b1, 4'd1, DEF_PAYLOAD_TYPE, 300, 188);
		trim(40);
		send_packet();
		build_rtp(RTP_VERSION, 1'b0, 4'd0, DEF_PAYLOAD_TYPE, 0, 20);
		send_packet();

		set_payload_type(7'd127);
		build_rtp(RTP_VERSION, 1'b0, 4'd2, 7'd127, 0, 0);
		send_packet();
		build_rtp(RTP_VERSION, 1'b0, 4'd0, 7'd0, 0, 4);
		send_packet();
		set_payload_type(7'd0);
		build_rtp(RTP_VERSION, 1'b1, 4'd3, 7'd0, 1, 8);
		send_packet();
		build_rtp(RTP_VERSION, 1'b0, 4'd0, 7'd127, 0, 0);
		send_packet();

		for (ph = 0; ph < PHASES; ph++) begin
			set_payload_type((ph == PHASES - 1) ? DEF_PAYLOAD_TYPE : 7'($urandom));
			phase_end = bytes_sent + (ITEM_BUDGET - bytes_sent) / (PHASES - ph);
			while (bytes_sent < phase_end)
				random_packet();
		end

		drain(10);
		$display("Covered %0d packets (%0d bytes) under %0d payload-type settings.",
			n_packets, bytes_sent, n_settings);
		$display("Checked %0d payload bytes and %0d packet reports; status codes seen %b.",
			n_payload, n_reports, status_mask);
		if (errors == 0 && waiting == 0)
			$display("rtp_mpeg_ts_depacketizer_tb passed");
		else
			$display("rtp_mpeg_ts_depacketizer_tb failed");
		$finish;
	end

endmodule
